// ===== src/tct_pkg.sv =====
// Package for the three-anchor trilateration block: field widths, item types,
// register indexes and the divider stage record. No dependencies.
package tct_pkg;

  // Lengths and ranges: unsigned; coordinates: signed; all with 4 fraction bits.
  localparam int LEN_W  = 18;
  localparam int POS_W  = LEN_W + 2;
  localparam int DIFF_W = LEN_W + 1;
  localparam int SQ_W   = 2 * LEN_W;
  localparam int K_W    = 2 * LEN_W + 3;
  localparam int KL_W   = LEN_W + 1;
  localparam int KH_W   = K_W - KL_W;
  localparam int PD_W   = 2 * DIFF_W;
  localparam int P_W    = DIFF_W + KH_W;
  localparam int DET_W  = 2 * LEN_W + 3;
  localparam int DEN_W  = DET_W + 1;
  localparam int NUM_W  = 3 * LEN_W + 4;
  localparam int Q_W    = POS_W;
  localparam int DIV_W  = DEN_W + Q_W;

  localparam logic signed [POS_W-1:0] POS_MAX = {1'b0, {(POS_W-1){1'b1}}};
  localparam logic signed [POS_W-1:0] POS_MIN = {1'b1, {(POS_W-1){1'b0}}};

  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ANCHOR_A_X = 3'd0,
    CFG_ANCHOR_A_Y = 3'd1,
    CFG_ANCHOR_B_X = 3'd2,
    CFG_ANCHOR_B_Y = 3'd3,
    CFG_ANCHOR_C_X = 3'd4,
    CFG_ANCHOR_C_Y = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic [LEN_W-1:0] range_a;
    logic [LEN_W-1:0] range_b;
    logic [LEN_W-1:0] range_c;
  } in_t;

  typedef struct packed {
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic                    collinear;
    logic                    clipped;
  } out_t;

  // One divider stage: partial remainders, shifted divisor, quotient so far.
  typedef struct packed {
    logic [DIV_W-1:0] rx;
    logic [DIV_W-1:0] ry;
    logic [DIV_W-1:0] dsh;
    logic [Q_W-1:0]   qx;
    logic [Q_W-1:0]   qy;
    logic             negx;
    logic             negy;
    logic             ovfx;
    logic             ovfy;
    logic             coll;
  } div_t;

endpackage

// ===== src/tct_div_step.sv =====
// One restoring-division stage shared by the x and y quotients.
// Depends on tct_pkg (div_t and widths).
module tct_div_step (
  input  logic          clk,
  input  logic          load,
  input  tct_pkg::div_t cur,
  output tct_pkg::div_t nxt
);
  import tct_pkg::*;

  div_t step;
  logic bitx;
  logic bity;

  // Subtract the shifted divisor where it fits, shift in one quotient bit each.
  always_comb begin
    step = cur;
    bitx = (cur.rx >= cur.dsh);
    bity = (cur.ry >= cur.dsh);
    if (bitx) begin
      step.rx = cur.rx - cur.dsh;
    end
    if (bity) begin
      step.ry = cur.ry - cur.dsh;
    end
    step.qx  = {cur.qx[Q_W-2:0], bitx};
    step.qy  = {cur.qy[Q_W-2:0], bity};
    step.dsh = cur.dsh >> 1;
  end

  always_ff @(posedge clk) begin
    if (load) begin
      nxt <= step;
    end
  end

endmodule

// ===== src/three_circle_trilateration_top.sv =====
// Top level of the three-anchor trilateration pipeline: anchor registers,
// arithmetic stages and handshake control. Depends on tct_pkg, tct_div_step.
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+-------------------------------
//   in      | in        | in_valid / in_ready   | in_item  (range_a/b/c)
//   out     | out       | out_valid / out_ready | out_item (pos_x/y, flags)
//   cfg     | in        | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// One item enters every cycle unless every stage is full and out_ready is low. The
// divider stages resolve one x and one y quotient bit per stage. Reset clears the
// anchors to zero and empties every stage. A stage holds while its successor is full
// and stalled; empty stages close up, so input is taken while a finished item waits
// at the output. cfg_ready is always high.
module three_circle_trilateration_top (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  tct_pkg::in_t                   in_item,
  output logic                           out_valid,
  input  logic                           out_ready,
  output tct_pkg::out_t                  out_item,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [tct_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tct_pkg::LEN_W-1:0]      cfg_data
);
  import tct_pkg::*;

  // Stage map: A squares, B sums and det products, C det and partial
  // products, D numerators, E magnitudes, F overflow check, then Q_W divider
  // stages, then the output register.
  localparam int ST_A   = 0;
  localparam int ST_B   = 1;
  localparam int ST_C   = 2;
  localparam int ST_D   = 3;
  localparam int ST_E   = 4;
  localparam int ST_F   = 5;
  localparam int ST_DIV = 6;
  localparam int ST_OUT = ST_DIV + Q_W;
  localparam int N_ST   = ST_OUT + 1;

  // ---------------------------------------------------------------------------
  // Anchor registers
  // ---------------------------------------------------------------------------
  logic [LEN_W-1:0] anchor_a_x, anchor_a_y;
  logic [LEN_W-1:0] anchor_b_x, anchor_b_y;
  logic [LEN_W-1:0] anchor_c_x, anchor_c_y;

  assign cfg_ready = 1'b1;

  // Drop writes to indexes beyond the register list.
  always_ff @(posedge clk) begin
    if (rst) begin
      anchor_a_x <= '0;
      anchor_a_y <= '0;
      anchor_b_x <= '0;
      anchor_b_y <= '0;
      anchor_c_x <= '0;
      anchor_c_y <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_ANCHOR_A_X: anchor_a_x <= cfg_data;
        CFG_ANCHOR_A_Y: anchor_a_y <= cfg_data;
        CFG_ANCHOR_B_X: anchor_b_x <= cfg_data;
        CFG_ANCHOR_B_Y: anchor_b_y <= cfg_data;
        CFG_ANCHOR_C_X: anchor_c_x <= cfg_data;
        CFG_ANCHOR_C_Y: anchor_c_y <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Pipeline control: one valid bit per stage. A stage may load when it is
  // empty or when some stage downstream of it is empty, or the output drains.
  // ---------------------------------------------------------------------------
  logic [N_ST-1:0] v;
  logic [N_ST-1:0] en;

  for (genvar i = 0; i < N_ST; i++) begin : g_en
    assign en[i] = out_ready || (v[N_ST-1:i] != '1);
  end

  assign in_ready  = en[ST_A];
  assign out_valid = v[ST_OUT];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) begin
        v[0] <= in_valid;
      end
      for (int i = 1; i < N_ST; i++) begin
        if (en[i]) begin
          v[i] <= v[i-1];
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage A: squares of ranges and anchors, anchor differences
  // ---------------------------------------------------------------------------
  logic [SQ_W-1:0] a_sq_ra, a_sq_rb, a_sq_rc;
  logic [SQ_W-1:0] a_sq_xa, a_sq_ya, a_sq_xb, a_sq_yb, a_sq_xc, a_sq_yc;
  logic signed [DIFF_W-1:0] a_dxab, a_dxbc, a_dyab, a_dybc;

  always_ff @(posedge clk) begin
    if (en[ST_A]) begin
      a_sq_ra <= SQ_W'(in_item.range_a) * SQ_W'(in_item.range_a);
      a_sq_rb <= SQ_W'(in_item.range_b) * SQ_W'(in_item.range_b);
      a_sq_rc <= SQ_W'(in_item.range_c) * SQ_W'(in_item.range_c);
      a_sq_xa <= SQ_W'(anchor_a_x) * SQ_W'(anchor_a_x);
      a_sq_ya <= SQ_W'(anchor_a_y) * SQ_W'(anchor_a_y);
      a_sq_xb <= SQ_W'(anchor_b_x) * SQ_W'(anchor_b_x);
      a_sq_yb <= SQ_W'(anchor_b_y) * SQ_W'(anchor_b_y);
      a_sq_xc <= SQ_W'(anchor_c_x) * SQ_W'(anchor_c_x);
      a_sq_yc <= SQ_W'(anchor_c_y) * SQ_W'(anchor_c_y);
      a_dxab  <= $signed({1'b0, anchor_a_x}) - $signed({1'b0, anchor_b_x});
      a_dxbc  <= $signed({1'b0, anchor_b_x}) - $signed({1'b0, anchor_c_x});
      a_dyab  <= $signed({1'b0, anchor_a_y}) - $signed({1'b0, anchor_b_y});
      a_dybc  <= $signed({1'b0, anchor_b_y}) - $signed({1'b0, anchor_c_y});
    end
  end

  // ---------------------------------------------------------------------------
  // Stage B: linear-equation constants and determinant products
  // ---------------------------------------------------------------------------
  logic signed [K_W-1:0]    b_kab, b_kbc;
  logic signed [PD_W-1:0]   b_pdet1, b_pdet2;
  logic signed [DIFF_W-1:0] b_dxab, b_dxbc, b_dyab, b_dybc;

  always_ff @(posedge clk) begin
    if (en[ST_B]) begin
      // Sums wrap in K_W bits; the true value always fits.
      b_kab   <= K_W'(a_sq_xb) - K_W'(a_sq_xa) + K_W'(a_sq_yb) - K_W'(a_sq_ya)
               + K_W'(a_sq_ra) - K_W'(a_sq_rb);
      b_kbc   <= K_W'(a_sq_xc) - K_W'(a_sq_xb) + K_W'(a_sq_yc) - K_W'(a_sq_yb)
               + K_W'(a_sq_rb) - K_W'(a_sq_rc);
      b_pdet1 <= PD_W'(a_dxab) * PD_W'(a_dybc);
      b_pdet2 <= PD_W'(a_dxbc) * PD_W'(a_dyab);
      b_dxab  <= a_dxab;
      b_dxbc  <= a_dxbc;
      b_dyab  <= a_dyab;
      b_dybc  <= a_dybc;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage C: determinant, and numerator products split on the K halves
  // ---------------------------------------------------------------------------
  logic signed [KL_W:0]   kab_l, kbc_l;
  logic signed [KH_W-1:0] kab_h, kbc_h;

  always_comb begin
    kab_l = $signed({1'b0, b_kab[KL_W-1:0]});
    kbc_l = $signed({1'b0, b_kbc[KL_W-1:0]});
    kab_h = b_kab[K_W-1:KL_W];
    kbc_h = b_kbc[K_W-1:KL_W];
  end

  logic signed [DET_W-1:0] c_det;
  logic signed [P_W-1:0]   c_x1l, c_x1h, c_x2l, c_x2h;
  logic signed [P_W-1:0]   c_y1l, c_y1h, c_y2l, c_y2h;

  always_ff @(posedge clk) begin
    if (en[ST_C]) begin
      c_det <= DET_W'(b_pdet1) - DET_W'(b_pdet2);
      c_x1l <= P_W'(b_dybc) * P_W'(kab_l);
      c_x1h <= P_W'(b_dybc) * P_W'(kab_h);
      c_x2l <= P_W'(b_dyab) * P_W'(kbc_l);
      c_x2h <= P_W'(b_dyab) * P_W'(kbc_h);
      c_y1l <= P_W'(b_dxbc) * P_W'(kab_l);
      c_y1h <= P_W'(b_dxbc) * P_W'(kab_h);
      c_y2l <= P_W'(b_dxab) * P_W'(kbc_l);
      c_y2h <= P_W'(b_dxab) * P_W'(kbc_h);
    end
  end

  // ---------------------------------------------------------------------------
  // Stage D: recombine partial products into the two numerators
  // ---------------------------------------------------------------------------
  logic signed [NUM_W-1:0] x1, x2, y1, y2;

  always_comb begin
    x1 = (NUM_W'(c_x1h) <<< KL_W) + NUM_W'(c_x1l);
    x2 = (NUM_W'(c_x2h) <<< KL_W) + NUM_W'(c_x2l);
    y1 = (NUM_W'(c_y1h) <<< KL_W) + NUM_W'(c_y1l);
    y2 = (NUM_W'(c_y2h) <<< KL_W) + NUM_W'(c_y2l);
  end

  logic signed [NUM_W-1:0] d_nx, d_ny;
  logic signed [DET_W-1:0] d_det;

  always_ff @(posedge clk) begin
    if (en[ST_D]) begin
      d_nx  <= x1 - x2;
      d_ny  <= y1 - y2;
      d_det <= c_det;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage E: signs and magnitudes. The x numerator is the negated nx.
  // ---------------------------------------------------------------------------
  logic [NUM_W-1:0] e_nxmag, e_nymag;
  logic [DEN_W-1:0] e_dmag;
  logic             e_negx, e_negy, e_coll;
  logic [DET_W-1:0] det_mag;
  logic             det_neg;

  always_comb begin
    det_neg = d_det[DET_W-1];
    det_mag = det_neg ? DET_W'(-d_det) : DET_W'(d_det);
  end

  always_ff @(posedge clk) begin
    if (en[ST_E]) begin
      e_nxmag <= d_nx[NUM_W-1] ? NUM_W'(-d_nx) : NUM_W'(d_nx);
      e_nymag <= d_ny[NUM_W-1] ? NUM_W'(-d_ny) : NUM_W'(d_ny);
      e_dmag  <= {det_mag, 1'b0};
      e_negx  <= (!d_nx[NUM_W-1] && (d_nx != '0)) != det_neg;
      e_negy  <= d_ny[NUM_W-1] != det_neg;
      e_coll  <= (d_det == '0);
    end
  end

  // ---------------------------------------------------------------------------
  // Stage F: quotients wider than Q_W bits saturate; seed the divider
  // ---------------------------------------------------------------------------
  div_t divs [Q_W+1];
  logic [DIV_W-1:0] den_top;

  assign den_top = DIV_W'(e_dmag) << Q_W;

  always_ff @(posedge clk) begin
    if (en[ST_F]) begin
      divs[0].rx   <= DIV_W'(e_nxmag);
      divs[0].ry   <= DIV_W'(e_nymag);
      divs[0].dsh  <= DIV_W'(e_dmag) << (Q_W - 1);
      divs[0].qx   <= '0;
      divs[0].qy   <= '0;
      divs[0].negx <= e_negx;
      divs[0].negy <= e_negy;
      divs[0].ovfx <= (DIV_W'(e_nxmag) >= den_top);
      divs[0].ovfy <= (DIV_W'(e_nymag) >= den_top);
      divs[0].coll <= e_coll;
    end
  end

  for (genvar j = 0; j < Q_W; j++) begin : g_div
    tct_div_step u_step (
      .clk  (clk),
      .load (en[ST_DIV + j]),
      .cur  (divs[j]),
      .nxt  (divs[j+1])
    );
  end

  // ---------------------------------------------------------------------------
  // Output stage: clamp, apply sign, force zero on collinear anchors
  // ---------------------------------------------------------------------------
  // Returns {clip, value}.
  function automatic logic [POS_W:0] sat_pos(input logic [Q_W-1:0] q,
                                            input logic neg, input logic ovf);
    logic [Q_W-1:0] bound;
    logic [Q_W-1:0] mag;
    logic           over;
    bound = neg ? (Q_W'(1) << (Q_W - 1)) : ((Q_W'(1) << (Q_W - 1)) - Q_W'(1));
    over  = ovf || (q > bound);
    mag   = over ? bound : q;
    return {over, (neg ? POS_W'(-mag) : POS_W'(mag))};
  endfunction

  logic [POS_W:0] sx, sy;
  out_t           res;

  always_comb begin
    sx = sat_pos(divs[Q_W].qx, divs[Q_W].negx, divs[Q_W].ovfx);
    sy = sat_pos(divs[Q_W].qy, divs[Q_W].negy, divs[Q_W].ovfy);
    if (divs[Q_W].coll) begin
      res.pos_x     = '0;
      res.pos_y     = '0;
      res.collinear = 1'b1;
      res.clipped   = 1'b0;
    end else begin
      res.pos_x     = sx[POS_W-1:0];
      res.pos_y     = sy[POS_W-1:0];
      res.collinear = 1'b0;
      res.clipped   = sx[POS_W] || sy[POS_W];
    end
  end

  always_ff @(posedge clk) begin
    if (en[ST_OUT]) begin
      out_item <= res;
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_flags_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_item.collinear && out_item.clipped))
    else $error("collinear and clipped both set");

  a_coll_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_item.collinear) |-> (out_item.pos_x == '0 && out_item.pos_y == '0))
    else $error("collinear item with nonzero position");

  a_clip_end: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_item.clipped) |->
      (out_item.pos_x == POS_MAX || out_item.pos_x == POS_MIN ||
       out_item.pos_y == POS_MAX || out_item.pos_y == POS_MIN))
    else $error("clipped item with no coordinate at a range end");

  a_take_when_free: assert property (@(posedge clk) disable iff (rst)
    (v != '1) |-> in_ready)
    else $error("input refused with an empty stage in the pipeline");

endmodule

// ===== tb/tct_position_checker.sv =====
// Position checker for the three-anchor trilateration block: mirrors anchor writes,
// predicts one position item per accepted range item and compares it with the output.
// Depends on tct_pkg.
module tct_position_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  tct_pkg::in_t                  in_item,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  tct_pkg::out_t                 out_item,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [tct_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tct_pkg::LEN_W-1:0]     cfg_data,
  output int                            fail_count,
  output int                            outstanding
);
  import tct_pkg::*;

  logic [LEN_W-1:0] ax = '0, ay = '0, bx = '0, by = '0, cx = '0, cy = '0;
  out_t pending_positions [$];
  out_t expected_pos;
  int   errors = 0;
  int   ranges_taken = 0;
  int   positions_seen = 0;

  assign fail_count  = errors;
  assign outstanding = ranges_taken - positions_seen;

  function automatic logic signed [POS_W-1:0] clamp_coord(input longint q, inout bit clip);
    if (q > longint'(POS_MAX)) begin
      clip = 1'b1;
      return POS_MAX;
    end
    if (q < longint'(POS_MIN)) begin
      clip = 1'b1;
      return POS_MIN;
    end
    return q[POS_W-1:0];
  endfunction

  // Subtract circle pairs, then Cramer's rule; quotients truncate toward zero.
  function automatic out_t solve_position(input in_t r);
    longint xa, ya, xb, yb, xc, yc, ra, rb, rc;
    longint kab, kbc, det, den, nx, ny;
    bit     clip;
    out_t   res;
    xa = longint'(ax);
    ya = longint'(ay);
    xb = longint'(bx);
    yb = longint'(by);
    xc = longint'(cx);
    yc = longint'(cy);
    ra = longint'(r.range_a);
    rb = longint'(r.range_b);
    rc = longint'(r.range_c);
    kab = xb*xb - xa*xa + yb*yb - ya*ya + ra*ra - rb*rb;
    kbc = xc*xc - xb*xb + yc*yc - yb*yb + rb*rb - rc*rc;
    det = (xa - xb) * (yb - yc) - (xb - xc) * (ya - yb);
    res = '0;
    if (det == 0) begin
      res.collinear = 1'b1;
      return res;
    end
    den  = 2 * det;
    nx   = (yb - yc) * kab - (ya - yb) * kbc;
    ny   = (xb - xc) * kab - (xa - xb) * kbc;
    clip = 1'b0;
    res.pos_x   = clamp_coord(-nx / den, clip);
    res.pos_y   = clamp_coord(ny / den, clip);
    res.clipped = clip;
    return res;
  endfunction

  task automatic report(input string what, input longint want, input longint got);
    $display("%0t: %s expected %0d, got %0d", $time, what, want, got);
    errors++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      ax <= '0;
      ay <= '0;
      bx <= '0;
      by <= '0;
      cx <= '0;
      cy <= '0;
      pending_positions.delete();
      ranges_taken   <= 0;
      positions_seen <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_ANCHOR_A_X: ax <= cfg_data;
          CFG_ANCHOR_A_Y: ay <= cfg_data;
          CFG_ANCHOR_B_X: bx <= cfg_data;
          CFG_ANCHOR_B_Y: by <= cfg_data;
          CFG_ANCHOR_C_X: cx <= cfg_data;
          CFG_ANCHOR_C_Y: cy <= cfg_data;
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        positions_seen <= positions_seen + 1;
        if (pending_positions.size() == 0) begin
          report("unexpected item, pos_x", 0, longint'(out_item.pos_x));
        end else begin
          expected_pos = pending_positions.pop_front();
          if (out_item.pos_x !== expected_pos.pos_x)
            report("pos_x", longint'(expected_pos.pos_x), longint'(out_item.pos_x));
          if (out_item.pos_y !== expected_pos.pos_y)
            report("pos_y", longint'(expected_pos.pos_y), longint'(out_item.pos_y));
          if (out_item.collinear !== expected_pos.collinear)
            report("collinear", expected_pos.collinear, out_item.collinear);
          if (out_item.clipped !== expected_pos.clipped)
            report("clipped", expected_pos.clipped, out_item.clipped);
        end
      end
      if (in_valid && in_ready) begin
        pending_positions = {pending_positions, solve_position(in_item)};
        ranges_taken <= ranges_taken + 1;
      end
    end
  end

endmodule

// ===== tb/tb_three_circle_trilateration_top.sv =====
// Testbench top for the three-anchor trilateration block: clock, reset, anchor
// writes, range stimulus, idling on both channels and the verdict.
// Depends on tct_pkg, three_circle_trilateration_top and tct_position_checker.
module tb_three_circle_trilateration_top;
  import tct_pkg::*;

  localparam int LEN_TOP      = 2**LEN_W - 1;
  localparam int HOLD_CYCLES  = 300;            // long receiver hold-off
  localparam int STALL_LIMIT  = 4000;           // cycles without any handshake
  localparam int DRAIN_CYCLES = Q_W + 7 + 16;   // pipeline latency plus margin
  localparam int PHASE_ITEMS  = 60;
  localparam int PHASES       = 8;

  // Indexes past the last anchor; writes to them must leave the anchors alone.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

  typedef enum logic [1:0] {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_t;

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 in_valid  = 1'b0;
  in_t                  in_item   = '0;
  logic                 out_ready = 1'b0;
  logic                 cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_ANCHOR_A_X;
  logic [LEN_W-1:0]     cfg_data  = '0;
  logic                 in_ready;
  logic                 out_valid;
  logic                 cfg_ready;
  out_t                 out_item;
  int                   fail_count;
  int                   outstanding;

  idle_mode_t idle_mode    = IDLE_NONE;
  logic       hold_arm     = 1'b0;
  logic       hold_done    = 1'b0;
  int         hold_left    = 0;
  int         quiet_cycles = 0;

  // Stimulus copy of the anchors, used only to make plausible ranges.
  int anchor_x [3] = '{0, 0, 0};
  int anchor_y [3] = '{0, 0, 0};
  int span = 0;

  three_circle_trilateration_top u_top (
    .clk,
    .rst,
    .in_valid,
    .in_ready,
    .in_item,
    .out_valid,
    .out_ready,
    .out_item,
    .cfg_valid,
    .cfg_ready,
    .cfg_index,
    .cfg_data
  );

  tct_position_checker u_checker (
    .clk,
    .rst,
    .in_valid,
    .in_ready,
    .in_item,
    .out_valid,
    .out_ready,
    .out_item,
    .cfg_valid,
    .cfg_ready,
    .cfg_index,
    .cfg_data,
    .fail_count,
    .outstanding
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Receiver: one long hold-off when armed, otherwise stall at the phase's rate.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_arm && !hold_done) begin
      out_ready <= 1'b0;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else begin
      case (idle_mode)
        IDLE_RECEIVER: out_ready <= ($urandom_range(99) >= 57);
        IDLE_BOTH:     out_ready <= ($urandom_range(99) >= 16);
        default:       out_ready <= 1'b1;
      endcase
    end
  end

  // Watchdog: give up once no channel has moved an item for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Wait until every range item taken has come back as a position item. Wait for
  // a clock edge before the first check so the item accepted at this edge is already counted.
  task automatic wait_drained();
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic write_anchor(input logic [CFG_IDX_W-1:0] idx, input int val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val[LEN_W-1:0];
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_ANCHOR_A_X: anchor_x[0] = val;
      CFG_ANCHOR_A_Y: anchor_y[0] = val;
      CFG_ANCHOR_B_X: anchor_x[1] = val;
      CFG_ANCHOR_B_Y: anchor_y[1] = val;
      CFG_ANCHOR_C_X: anchor_x[2] = val;
      CFG_ANCHOR_C_Y: anchor_y[2] = val;
      default: ;
    endcase
  endtask

  // Drain first so nothing is in flight, then write all six anchors, then
  // poke both spare indexes with random data.
  task automatic load_anchors(input int xa, input int ya, input int xb, input int yb,
                              input int xc, input int yc, input int region);
    wait_drained();
    write_anchor(CFG_ANCHOR_A_X, xa);
    write_anchor(CFG_ANCHOR_A_Y, ya);
    write_anchor(CFG_ANCHOR_B_X, xb);
    write_anchor(CFG_ANCHOR_B_Y, yb);
    write_anchor(CFG_ANCHOR_C_X, xc);
    write_anchor(CFG_ANCHOR_C_Y, yc);
    write_anchor(CFG_SPARE_LO, $urandom_range(0, LEN_TOP));
    write_anchor(CFG_SPARE_HI, $urandom_range(0, LEN_TOP));
    cfg_valid <= 1'b0;
    span = region;
  endtask

  // Offer one range item and hold it until taken; the sender may idle first.
  task automatic send_ranges(input int ra, input int rb, input int rc);
    int gap_pct;
    gap_pct = (idle_mode == IDLE_SENDER) ? 57 : (idle_mode == IDLE_BOTH) ? 16 : 0;
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= '{range_a: ra[LEN_W-1:0], range_b: rb[LEN_W-1:0], range_c: rc[LEN_W-1:0]};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Distance from landmark k to a point, plus jitter, clamped to the field.
  function automatic int range_from(input int k, input int px, input int py, input int jitter);
    real dx, dy;
    int  d;
    dx = real'(px) - real'(anchor_x[k]);
    dy = real'(py) - real'(anchor_y[k]);
    d  = $rtoi($sqrt(dx * dx + dy * dy)) + jitter;
    if (d < 0) d = 0;
    if (d > LEN_TOP) d = LEN_TOP;
    return d;
  endfunction

  task automatic send_point(input int px, input int py, input int jitter);
    send_ranges(range_from(0, px, py, jitter), range_from(1, px, py, jitter),
                range_from(2, px, py, jitter));
  endtask

  function automatic int edge_range();
    case ($urandom_range(2))
      0:       return 0;
      1:       return LEN_TOP;
      default: return $urandom_range(0, LEN_TOP);
    endcase
  endfunction

  // Mostly consistent fixes around the anchors; the rest raw and extreme ranges.
  task automatic send_random_item();
    int pick;
    int px, py;
    pick = $urandom_range(99);
    px   = $urandom_range(0, span);
    py   = $urandom_range(0, span);
    if (pick < 75)
      send_point(px, py, $urandom_range(0, 32) - 16);
    else if (pick < 90)
      send_ranges($urandom_range(0, LEN_TOP), $urandom_range(0, LEN_TOP),
                  $urandom_range(0, LEN_TOP));
    else
      send_ranges(edge_range(), edge_range(), edge_range());
  endtask

  initial begin
    int region;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Anchors still at reset: all three coincide, so every fix is collinear.
    send_ranges(0, 0, 0);
    send_ranges(LEN_TOP, LEN_TOP, LEN_TOP);
    send_ranges(18'h2AAAA, 18'h15555, 18'h2AAAA);
    in_valid <= 1'b0;

    // Right-angled triangle of 100 cells: exact fixes, zero and full ranges.
    load_anchors(0, 0, 1600, 0, 0, 1600, 1600);
    send_point(800, 800, 0);
    send_point(0, 0, 0);
    send_point(1600, 1600, 0);
    send_ranges(0, 0, 0);
    send_ranges(LEN_TOP, LEN_TOP, LEN_TOP);
    send_ranges(LEN_TOP, 0, 0);
    send_ranges(0, LEN_TOP, 0);
    send_ranges(0, 0, LEN_TOP);
    in_valid <= 1'b0;

    // Unit triangle: determinant of one, so large ranges saturate both ways.
    load_anchors(0, 0, 1, 0, 0, 1, 2);
    send_ranges(0, 1, 1);
    send_ranges(LEN_TOP, 0, LEN_TOP);
    send_ranges(0, LEN_TOP, 0);
    in_valid <= 1'b0;

    // Anchors on the corners of the field.
    load_anchors(LEN_TOP, LEN_TOP, 0, LEN_TOP, LEN_TOP, 0, LEN_TOP);
    send_ranges(LEN_TOP, LEN_TOP, LEN_TOP);
    send_ranges(0, 0, 0);
    send_point(LEN_TOP / 2, LEN_TOP / 3, 0);
    in_valid <= 1'b0;

    // Distinct anchors on one line: still collinear.
    load_anchors(16, 16, 1600, 1600, LEN_TOP, LEN_TOP, LEN_TOP);
    send_ranges(1000, 2000, 3000);
    in_valid <= 1'b0;

    // Random anchors at several scales, cycling through the idling styles.
    // The first phase also holds the receiver off so the pipeline backs up.
    for (int p = 0; p < PHASES; p++) begin
      case ($urandom_range(3))
        0:       region = 64;
        1:       region = 4096;
        2:       region = 65535;
        default: region = LEN_TOP;
      endcase
      load_anchors($urandom_range(0, region), $urandom_range(0, region),
                   $urandom_range(0, region), $urandom_range(0, region),
                   $urandom_range(0, region), $urandom_range(0, region), region);
      idle_mode <= idle_mode_t'(p % 4);
      if (p == 0) hold_arm <= 1'b1;
      @(posedge clk);
      for (int i = 0; i < PHASE_ITEMS; i++) send_random_item();
      in_valid <= 1'b0;
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
